// ----- rtl/lpe_pkg.sv -----
// shared types and constants for the legendre polynomial evaluator
`timescale 1ns / 1ps

package lpe_pkg;

   // field widths
   localparam int ORDER_W = 6;
   localparam int DATA_W  = 32;

   // default highest order
   localparam int MAX_ORDER_DEF = 32;

   // register stages inside one recurrence cell
   localparam int CELL_STAGES = 6;

   // 1.0 in q2.30
   localparam logic signed [DATA_W-1:0] ONE_Q30 = 32'sh4000_0000;

   // operands that travel along the chain with each transaction
   typedef struct packed {
      logic        [ORDER_W-1:0] order;
      logic signed [DATA_W-1:0]  x;
      logic signed [DATA_W-1:0]  prev;
      logic signed [DATA_W-1:0]  cur;
   } token_type;

endpackage

// ----- rtl/lpe_cell.sv -----
// one bonnet recurrence step, six register stages, applied when step < order
`timescale 1ns / 1ps

module lpe_cell #(
   parameter int STEP = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  lpe_pkg::token_type in_tok,
   output logic               out_valid,
   output lpe_pkg::token_type out_tok
);
   import lpe_pkg::*;

   // step constants: 2i+1, i and round(2^32/(i+1))
   localparam logic signed [7:0] COEF_A = 8'(2 * STEP + 1);
   localparam logic signed [7:0] COEF_B = 8'(STEP);
   localparam logic [32:0] RECIP_WIDE =
      33'(((64'd1 << 32) + 64'((STEP + 1) >> 1)) / 64'(STEP + 1));
   localparam logic [31:0] RECIP = RECIP_WIDE[31:0];

   logic [CELL_STAGES-1:0] valid_ff;
   logic [CELL_STAGES-1:0] valid_in;
   token_type              tok_ff [CELL_STAGES];
   token_type              tok_in [CELL_STAGES];

   logic [63:0]        prod_ff, prod_in;
   logic               pneg_ff, pneg_in;
   logic signed [33:0] m_ff, m_in;
   logic signed [42:0] a_ff, a_in;
   logic signed [42:0] b_ff, b_in;
   logic [9:0]         hi_ff, hi_in;
   logic [31:0]        lo_ff, lo_in;
   logic               tneg_ff, tneg_in;
   logic [41:0]        ph_ff, ph_in;
   logic [63:0]        pl_ff, pl_in;
   logic               qneg_ff, qneg_in;

   logic [31:0]        mag_x;
   logic [31:0]        mag_cur;
   logic [32:0]        m_mag;
   logic signed [33:0] m_pos;
   logic signed [42:0] t_val;
   logic signed [42:0] t_abs;
   logic [64:0]        pl_round;
   logic [42:0]        q_mag;
   logic signed [31:0] nxt;
   logic               active;

   // valid and operand shift line
   always_comb begin
      valid_in = {valid_ff[CELL_STAGES-2:0], in_valid};
      tok_in[0] = in_tok;
      for (int s = 1; s < CELL_STAGES; s++) begin
         tok_in[s] = tok_ff[s-1];
      end
      tok_in[CELL_STAGES-1].prev = tok_ff[CELL_STAGES-2].prev;
      tok_in[CELL_STAGES-1].cur  = tok_ff[CELL_STAGES-2].cur;
      if (active) begin
         tok_in[CELL_STAGES-1].prev = tok_ff[CELL_STAGES-2].cur;
         tok_in[CELL_STAGES-1].cur  = nxt;
      end
   end

   // stage 1: magnitude product x * p(i)
   always_comb begin
      mag_x   = in_tok.x[31] ? 32'(-in_tok.x) : 32'(in_tok.x);
      mag_cur = in_tok.cur[31] ? 32'(-in_tok.cur) : 32'(in_tok.cur);
      prod_in = 64'(mag_x) * 64'(mag_cur);
      pneg_in = in_tok.x[31] ^ in_tok.cur[31];
   end

   // stage 2: back to q2.30, round half away from zero
   always_comb begin
      m_mag = 33'((prod_ff + (64'd1 << 29)) >> 30);
      m_pos = $signed({1'b0, m_mag});
      m_in  = pneg_ff ? -m_pos : m_pos;
   end

   // stage 3: constant scaling of both terms
   always_comb begin
      a_in = 43'(m_ff) * 43'(COEF_A);
      b_in = 43'(tok_ff[1].prev) * 43'(COEF_B);
   end

   // stage 4: difference, split into magnitude halves
   always_comb begin
      t_val   = a_ff - b_ff;
      tneg_in = t_val[42];
      t_abs   = t_val[42] ? -t_val : t_val;
      hi_in   = t_abs[41:32];
      lo_in   = t_abs[31:0];
   end

   // stage 5: partial products with the reciprocal
   always_comb begin
      ph_in   = 42'(hi_ff) * 42'(RECIP);
      pl_in   = 64'(lo_ff) * 64'(RECIP);
      qneg_in = tneg_ff;
   end

   // stage 6: sum, round, sign and saturate
   always_comb begin
      pl_round = 65'(pl_ff) + (65'd1 << 31);
      q_mag    = 43'(ph_ff) + 43'(pl_round[64:32]);
      if (!qneg_ff) begin
         nxt = (q_mag > 43'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q_mag[31:0]);
      end else begin
         nxt = (q_mag > 43'h0_8000_0000) ? 32'sh8000_0000 : $signed(-q_mag[31:0]);
      end
      active = 7'(tok_ff[CELL_STAGES-2].order) > 7'(STEP);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tok_ff  <= tok_in;
      prod_ff <= prod_in;
      pneg_ff <= pneg_in;
      m_ff    <= m_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      tneg_ff <= tneg_in;
      ph_ff   <= ph_in;
      pl_ff   <= pl_in;
      qneg_ff <= qneg_in;
   end

   assign out_valid = valid_ff[CELL_STAGES-1];
   assign out_tok   = tok_ff[CELL_STAGES-1];

endmodule

// ----- rtl/legendre_polynomial_eval_core.sv -----
// top level of the legendre polynomial evaluator: input register, cell chain, result register
//
//   channel  | ports                           | handshake
//   ---------+---------------------------------+--------------------------------
//   request  | start, busy, req_order,         | taken at edge with start & !busy
//            | req_cosine                      |
//   response | rsp_valid, rsp_value            | one-cycle strobe, no back-pressure
//
// a transaction enters every cycle while busy is low and passes the input register, the chain
// of MAX_ORDER-1 recurrence cells of six stages each and the result register.
// results leave in the order of their requests, one per request.
// busy is high only while reset is high; reset clears all valid bits, dropping work
// in flight. the receiver cannot stall, so nothing holds the pipeline.
`timescale 1ns / 1ps

module legendre_polynomial_eval_core #(
   parameter int MAX_ORDER = lpe_pkg::MAX_ORDER_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic        [lpe_pkg::ORDER_W-1:0] req_order,
   input  logic signed [lpe_pkg::DATA_W-1:0]  req_cosine,
   output logic                               rsp_valid,
   output logic signed [lpe_pkg::DATA_W-1:0]  rsp_value
);
   import lpe_pkg::*;

   localparam int CELLS = MAX_ORDER - 1;

   logic                      in_valid_ff, in_valid_in;
   token_type                 in_tok_ff, in_tok_in;
   logic [ORDER_W-1:0]        order_clamp;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]  rsp_value_ff, rsp_value_in;

   logic                      chain_valid [CELLS+1];
   token_type                 chain_tok   [CELLS+1];

   // no transaction is taken while reset is high
   assign busy = reset;

   // clamp the order and seed p0 and p1
   always_comb begin
      order_clamp = (7'(req_order) > 7'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : req_order;
      in_valid_in = start && !busy;
      in_tok_in.order = order_clamp;
      in_tok_in.x     = req_cosine;
      in_tok_in.prev  = ONE_Q30;
      in_tok_in.cur   = (order_clamp == '0) ? ONE_Q30 : req_cosine;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_tok_ff <= in_tok_in;
   end

   assign chain_valid[0] = in_valid_ff;
   assign chain_tok[0]   = in_tok_ff;

   // one cell per recurrence step
   for (genvar g = 1; g <= CELLS; g++) begin : g_cell
      lpe_cell #(
         .STEP (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g-1]),
         .in_tok    (chain_tok[g-1]),
         .out_valid (chain_valid[g]),
         .out_tok   (chain_tok[g])
      );
   end

   // result register
   always_comb begin
      rsp_valid_in = chain_valid[CELLS];
      rsp_value_in = chain_tok[CELLS].cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

// ----- rtl/lpe_checker.sv -----
// port-level assertions for the legendre polynomial evaluator, bound to the top level
`timescale 1ns / 1ps

module lpe_checker #(
   parameter int MAX_ORDER = lpe_pkg::MAX_ORDER_DEF
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic        [lpe_pkg::ORDER_W-1:0] req_order,
   input logic signed [lpe_pkg::DATA_W-1:0]  req_cosine,
   input logic                               rsp_valid,
   input logic signed [lpe_pkg::DATA_W-1:0]  rsp_value
);
   import lpe_pkg::*;

   localparam int LAT = CELL_STAGES * (MAX_ORDER - 1) + 2;

   // every accepted transaction gives a result after the fixed latency
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("missing result after accepted transaction");

   // no result without a transaction taken at the matching edge
   a_rsp_caused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without matching transaction");

   // order zero yields 1.0
   a_order_zero: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_order == '0) |-> ##LAT (rsp_value == ONE_Q30))
      else $error("order zero result is not 1.0");

   // order one yields the cosine itself
   a_order_one: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_order == ORDER_W'(1)) |->
         ##LAT (rsp_value == $past(req_cosine, LAT)))
      else $error("order one result differs from cosine");

endmodule

bind legendre_polynomial_eval_core lpe_checker #(
   .MAX_ORDER (MAX_ORDER)
) u_lpe_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_order  (req_order),
   .req_cosine (req_cosine),
   .rsp_valid  (rsp_valid),
   .rsp_value  (rsp_value)
);
